>>> rtl/srsw_pkg.sv
// Shared types and constants of the selective-repeat sender window.
package srsw_pkg;

	localparam int OP_W       = 2;
	localparam int STAT_W     = 3;
	localparam int WIN_W      = 3;
	localparam int TMR_W      = 27;
	localparam int TOT_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;

	localparam logic [WIN_W-1:0] WINDOW_RESET  = 3'd3;
	localparam logic [TMR_W-1:0] TIMEOUT_RESET = 27'd100000000;
	localparam logic [TMR_W-1:0] TIMER_MAX     = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_OFFER = 2'd0,
		OP_ACK   = 2'd1,
		OP_NAK   = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_SENT    = 3'd0,
		STAT_REFUSED = 3'd1,
		STAT_ACKED   = 3'd2,
		STAT_NAK     = 3'd3,
		STAT_TIMEOUT = 3'd4,
		STAT_IDLE    = 3'd5,
		STAT_BADSEQ  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_NAK_RD,
		S_TICK
	} state_t;

endpackage

>>> rtl/srsw_in_if.sv
// Input channel of the sender window: one operation beat.
interface srsw_in_if #(
	parameter int SEQ_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
);
	import srsw_pkg::*;

	logic                    valid;
	logic                    ready;
	op_t                     operation;
	logic [SEQ_BITS-1:0]     frame_seq;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, operation, frame_seq, payload, input ready);
	modport sink   (input valid, operation, frame_seq, payload, output ready);
endinterface

>>> rtl/srsw_out_if.sv
// Result channel of the sender window: one status beat per operation.
interface srsw_out_if #(
	parameter int SEQ_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
);
	import srsw_pkg::*;

	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic                    tx_valid;
	logic [SEQ_BITS-1:0]     tx_seq;
	logic [PAYLOAD_BITS-1:0] tx_payload;
	logic [SEQ_BITS-1:0]     base_seq;
	logic [SEQ_BITS-1:0]     next_seq;
	logic                    done_res;

	modport source (output valid, status, tx_valid, tx_seq, tx_payload, base_seq,
		next_seq, done_res, input ready);
	modport sink   (input valid, status, tx_valid, tx_seq, tx_payload, base_seq,
		next_seq, done_res, output ready);
endinterface

>>> rtl/selective_repeat_sender_window_top.sv
// Top level of the selective-repeat sender window: slot memories, counters and control.
// Offer and ack return their result in the cycle after the input beat; a nak first reads
// the payload memory (S_NAK_RD); a tick walks the outstanding frames from the oldest up
// to the one that times out (at most the window, so SLOTS), one slot per S_TICK step.
// Flow: one operation at a time; a beat is taken only in S_IDLE with the output register free.
// Reset: counters, walk state, config and out_valid_q return to defaults; slot memories are
// not cleared, since only outstanding slots are read and every one was written on send.
module selective_repeat_sender_window_top #(
	parameter int SLOTS        = 4,
	parameter int SEQ_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
	srsw_in_if.sink                           in_ch,
	srsw_out_if.source                        out_ch
);
	import srsw_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SUM_W  = ((SLOT_W > SEQ_BITS) ? SLOT_W : SEQ_BITS) + 1;

	// Step a slot index along with its sequence number: a wrap of the sequence
	// counter restarts the slot at zero, otherwise the slot wraps at SLOTS.
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot,
		input logic [SEQ_BITS-1:0] seq);
		logic [SLOT_W-1:0] res;
		if (seq == '1 || slot == SLOT_W'(SLOTS - 1)) begin
			res = '0;
		end else begin
			res = slot + SLOT_W'(1);
		end
		return res;
	endfunction

	// Configuration registers
	logic [WIN_W-1:0]  window_q;
	logic [TMR_W-1:0]  limit_q;
	logic [TOT_W-1:0]  total_q;

	// Window counters; base_slot_q and next_slot_q track the counters modulo SLOTS
	state_t              state_q, state_d;
	logic [SEQ_BITS-1:0] base_q, base_d, next_q, next_d;
	logic [SLOT_W-1:0]   base_slot_q, base_slot_d, next_slot_q, next_slot_d;

	// Walk state of a tick, also holds the sequence number of a nak
	logic [SEQ_BITS-1:0] walk_seq_q, walk_seq_d;
	logic [SLOT_W-1:0]   walk_slot_q, walk_slot_d;
	logic [WIN_W-1:0]    walk_k_q, walk_k_d, walk_last_q, walk_last_d;

	// Output register
	logic                    out_valid_q, out_valid_d;
	status_t                 out_status_q, out_status_d;
	logic                    out_tx_valid_q, out_tx_valid_d;
	logic [SEQ_BITS-1:0]     out_tx_seq_q, out_tx_seq_d;
	logic [PAYLOAD_BITS-1:0] out_tx_payload_q, out_tx_payload_d;
	logic [SEQ_BITS-1:0]     out_base_q, out_next_q;
	logic                    out_done_q;
	logic                    load_out;

	// Slot memories: one write port and one registered read port each
	logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
	logic [TMR_W-1:0]        tmr_mem [SLOTS];
	logic [PAYLOAD_BITS-1:0] pay_rd_q;
	logic [TMR_W-1:0]        tmr_rd_q;
	logic                    pay_we, tmr_we, rd_en;
	logic [SLOT_W-1:0]       wr_slot, rd_slot;
	logic [TMR_W-1:0]        tmr_wdata;

	// Decode helpers
	logic                    accept, out_free, room, seq_ok, fire;
	logic [WIN_W-1:0]        eff_w;
	logic [SEQ_BITS-1:0]     out_cnt, d_seq;
	logic [SUM_W-1:0]        seq_sum;
	logic [SLOT_W-1:0]       seq_slot;
	logic [TMR_W-1:0]        tmr_inc;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && out_free;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = out_status_q;
	assign out_ch.tx_valid   = out_tx_valid_q;
	assign out_ch.tx_seq     = out_tx_seq_q;
	assign out_ch.tx_payload = out_tx_payload_q;
	assign out_ch.base_seq   = out_base_q;
	assign out_ch.next_seq   = out_next_q;
	assign out_ch.done_res   = out_done_q;

	// Effective window: zero acts as one, anything above SLOTS as SLOTS
	always_comb begin
		if (window_q == '0) begin
			eff_w = WIN_W'(1);
		end else if (int'(window_q) > SLOTS) begin
			eff_w = WIN_W'(SLOTS);
		end else begin
			eff_w = window_q;
		end
	end

	assign out_cnt = next_q - base_q;
	assign room    = out_cnt < SEQ_BITS'(eff_w);
	assign d_seq   = in_ch.frame_seq - base_q;
	assign seq_ok  = d_seq < out_cnt;
	assign seq_sum = SUM_W'(base_slot_q) + SUM_W'(d_seq);

	// Slot of an outstanding frame_seq without a divider: offset from the base slot,
	// or the raw number when the sequence counter wrapped between base and frame_seq.
	always_comb begin
		if (in_ch.frame_seq < base_q) begin
			seq_slot = SLOT_W'(in_ch.frame_seq);
		end else if (seq_sum >= SUM_W'(SLOTS)) begin
			seq_slot = SLOT_W'(seq_sum - SUM_W'(SLOTS));
		end else begin
			seq_slot = SLOT_W'(seq_sum);
		end
	end

	// Saturating timer increment of the slot under the walk
	assign tmr_inc = (tmr_rd_q == TIMER_MAX) ? TIMER_MAX : tmr_rd_q + TMR_W'(1);
	assign fire    = tmr_inc > limit_q;

	// Next state, memory commands and result
	always_comb begin
		state_d          = state_q;
		base_d           = base_q;
		next_d           = next_q;
		base_slot_d      = base_slot_q;
		next_slot_d      = next_slot_q;
		walk_seq_d       = walk_seq_q;
		walk_slot_d      = walk_slot_q;
		walk_k_d         = walk_k_q;
		walk_last_d      = walk_last_q;
		load_out         = 1'b0;
		out_status_d     = STAT_IDLE;
		out_tx_valid_d   = 1'b0;
		out_tx_seq_d     = '0;
		out_tx_payload_d = '0;
		pay_we           = 1'b0;
		tmr_we           = 1'b0;
		rd_en            = 1'b0;
		wr_slot          = next_slot_q;
		rd_slot          = base_slot_q;
		tmr_wdata        = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_ch.operation)
						OP_OFFER: begin
							load_out = 1'b1;
							if (room && next_q != SEQ_BITS'(total_q)) begin
								// Store the frame and start its timer at zero
								pay_we           = 1'b1;
								tmr_we           = 1'b1;
								wr_slot          = next_slot_q;
								out_status_d     = STAT_SENT;
								out_tx_valid_d   = 1'b1;
								out_tx_seq_d     = next_q;
								out_tx_payload_d = in_ch.payload;
								next_d           = next_q + SEQ_BITS'(1);
								next_slot_d      = slot_inc(next_slot_q, next_q);
							end else begin
								out_status_d = STAT_REFUSED;
							end
						end
						OP_ACK: begin
							load_out = 1'b1;
							if (seq_ok) begin
								// Retire everything up to frame_seq in one move; retired
								// timers are never read before the slot is sent again.
								out_status_d = STAT_ACKED;
								base_d       = in_ch.frame_seq + SEQ_BITS'(1);
								base_slot_d  = slot_inc(seq_slot, in_ch.frame_seq);
							end else begin
								out_status_d = STAT_BADSEQ;
							end
						end
						OP_NAK: begin
							if (seq_ok) begin
								rd_en      = 1'b1;
								rd_slot    = seq_slot;
								tmr_we     = 1'b1;
								wr_slot    = seq_slot;
								walk_seq_d = in_ch.frame_seq;
								state_d    = S_NAK_RD;
							end else begin
								load_out     = 1'b1;
								out_status_d = STAT_BADSEQ;
							end
						end
						OP_TICK: begin
							if (out_cnt == '0) begin
								load_out     = 1'b1;
								out_status_d = STAT_IDLE;
							end else begin
								rd_en       = 1'b1;
								rd_slot     = base_slot_q;
								walk_slot_d = base_slot_q;
								walk_seq_d  = base_q;
								walk_k_d    = '0;
								walk_last_d = WIN_W'(out_cnt - SEQ_BITS'(1));
								state_d     = S_TICK;
							end
						end
						default: ;
					endcase
				end
			end
			S_NAK_RD: begin
				if (out_free) begin
					load_out         = 1'b1;
					out_status_d     = STAT_NAK;
					out_tx_valid_d   = 1'b1;
					out_tx_seq_d     = walk_seq_q;
					out_tx_payload_d = pay_rd_q;
					state_d          = S_IDLE;
				end
			end
			S_TICK: begin
				if (out_free) begin
					// Write back this slot's timer; if the walk goes on, the next slot is read meanwhile
					tmr_we    = 1'b1;
					wr_slot   = walk_slot_q;
					tmr_wdata = fire ? '0 : tmr_inc;
					if (fire) begin
						load_out         = 1'b1;
						out_status_d     = STAT_TIMEOUT;
						out_tx_valid_d   = 1'b1;
						out_tx_seq_d     = walk_seq_q;
						out_tx_payload_d = pay_rd_q;
						state_d          = S_IDLE;
					end else if (walk_k_q == walk_last_q) begin
						load_out     = 1'b1;
						out_status_d = STAT_IDLE;
						state_d      = S_IDLE;
					end else begin
						rd_en       = 1'b1;
						rd_slot     = slot_inc(walk_slot_q, walk_seq_q);
						walk_slot_d = slot_inc(walk_slot_q, walk_seq_q);
						walk_seq_d  = walk_seq_q + SEQ_BITS'(1);
						walk_k_d    = walk_k_q + WIN_W'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ch.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[wr_slot] <= in_ch.payload;
		end
		if (rd_en) begin
			pay_rd_q <= pay_mem[rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (tmr_we) begin
			tmr_mem[wr_slot] <= tmr_wdata;
		end
		if (rd_en) begin
			tmr_rd_q <= tmr_mem[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			limit_q  <= TIMEOUT_RESET;
			total_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW:  window_q <= cfg_data[WIN_W-1:0];
				CFG_TIMEOUT: limit_q  <= cfg_data[TMR_W-1:0];
				CFG_TOTAL:   total_q  <= cfg_data[TOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			base_slot_q <= '0;
			next_slot_q <= '0;
			walk_seq_q  <= '0;
			walk_slot_q <= '0;
			walk_k_q    <= '0;
			walk_last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			base_q      <= base_d;
			next_q      <= next_d;
			base_slot_q <= base_slot_d;
			next_slot_q <= next_slot_d;
			walk_seq_q  <= walk_seq_d;
			walk_slot_q <= walk_slot_d;
			walk_k_q    <= walk_k_d;
			walk_last_q <= walk_last_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Result beat; base and next report the counters after the operation
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q     <= out_status_d;
			out_tx_valid_q   <= out_tx_valid_d;
			out_tx_seq_q     <= out_tx_seq_d;
			out_tx_payload_q <= out_tx_payload_d;
			out_base_q       <= base_d;
			out_next_q       <= next_d;
			out_done_q       <= (base_d == SEQ_BITS'(total_q));
		end
	end

`ifndef SYNTHESIS
	a_outstanding_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(out_cnt) <= SLOTS)
		else $error("more frames outstanding than slots");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TICK |-> walk_k_q <= walk_last_q)
		else $error("tick walk ran past the outstanding frames");

	a_single_cycle_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_ch.operation == OP_OFFER || in_ch.operation == OP_ACK)
		|=> out_valid_q)
		else $error("offer or ack beat gave no result on the next cycle");

	a_quiet_tx_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_tx_valid_q |-> out_tx_seq_q == '0 && out_tx_payload_q == '0)
		else $error("tx fields not zero on a beat without a transmitted frame");
`endif

endmodule

>>> tb/sv/tb_selective_repeat_sender_window_top.sv
// Self-checking testbench of the selective-repeat sender window: directed and random operation beats.
module tb_selective_repeat_sender_window_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srsw_pkg::*;

	localparam int SLOTS         = 4;
	localparam int SLOT_W        = $clog2(SLOTS);
	localparam int MAX_WAIT      = 18;
	localparam int SETTLE_CYCLES = 12;    // long enough for the longest tick walk to finish
	localparam int QUIET_LIMIT   = 2000;  // sender gap + walk + receiver stall, many times over
	localparam int PHASES        = 9;
	localparam int PHASE_BEATS   = 150;
	localparam int MODE_SPAN     = 50;    // beats between changes of idling style

	// index that maps to no register; a write to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		op_t         operation;
		logic [15:0] frame_seq;
		logic [31:0] payload;
	} frame_op_t;

	typedef struct {
		status_t     status;
		logic        tx_valid;
		logic [15:0] tx_seq;
		logic [31:0] tx_payload;
		logic [15:0] base_seq;
		logic [15:0] next_seq;
		logic        done_res;
	} window_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	srsw_in_if  in_ch ();
	srsw_out_if out_ch ();

	selective_repeat_sender_window_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow of the window: registers, slot memories and sequence counters.
	logic [WIN_W-1:0] win_reg;
	logic [TMR_W-1:0] tmo_reg;
	logic [TOT_W-1:0] total_reg;
	logic [31:0]      slot_pay [SLOTS];
	logic [TMR_W-1:0] slot_tmr [SLOTS];
	logic [15:0]      base_ctr;
	logic [15:0]      next_ctr;

	frame_op_t      beats_to_send [$];  // operations waiting for the driver
	window_result_t results_due [$];    // predicted results, oldest first
	frame_op_t      on_wire;            // operation currently offered on in_ch

	int errors       = 0;
	int results_seen = 0;
	int gap_left     = 0;
	int stall_left   = 0;
	int send_mode    = 1;
	int take_mode    = 1;
	int sent_beats   = 0;
	int taken_beats  = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Slot that holds a sequence number.
	function automatic logic [SLOT_W-1:0] slot_of(logic [15:0] seq);
		return SLOT_W'(seq % 16'(SLOTS));
	endfunction

	// Apply one operation to the shadow window and return the result it must produce.
	function automatic window_result_t advance_window(frame_op_t it);
		window_result_t    r;
		logic [15:0]       outst;
		logic [15:0]       offs;
		logic [15:0]       q;
		logic [WIN_W-1:0]  win;
		logic [SLOT_W-1:0] s;
		logic              fired;
		int                k;
		r.status     = STAT_IDLE;
		r.tx_valid   = 1'b0;
		r.tx_seq     = '0;
		r.tx_payload = '0;
		outst = next_ctr - base_ctr;
		offs  = it.frame_seq - base_ctr;
		// window register 0 acts as 1, anything past the slot count as the slot count
		win = (win_reg == '0) ? WIN_W'(1) : ((win_reg > WIN_W'(SLOTS)) ? WIN_W'(SLOTS) : win_reg);
		case (it.operation)
			OP_OFFER: begin
				if (outst < 16'(win) && next_ctr != total_reg) begin
					s = slot_of(next_ctr);
					slot_pay[s]  = it.payload;
					slot_tmr[s]  = '0;
					r.status     = STAT_SENT;
					r.tx_valid   = 1'b1;
					r.tx_seq     = next_ctr;
					r.tx_payload = it.payload;
					next_ctr     = next_ctr + 16'd1;
				end else begin
					r.status = STAT_REFUSED;
				end
			end
			OP_ACK: begin
				// cumulative: retire every frame up to and including the named one
				if (offs < outst) begin
					for (k = 0; k <= int'(offs); k++) begin
						slot_tmr[slot_of(base_ctr)] = '0;
						base_ctr = base_ctr + 16'd1;
					end
					r.status = STAT_ACKED;
				end else begin
					r.status = STAT_BADSEQ;
				end
			end
			OP_NAK: begin
				if (offs < outst) begin
					s = slot_of(it.frame_seq);
					slot_tmr[s]  = '0;
					r.status     = STAT_NAK;
					r.tx_valid   = 1'b1;
					r.tx_seq     = it.frame_seq;
					r.tx_payload = slot_pay[s];
				end else begin
					r.status = STAT_BADSEQ;
				end
			end
			default: begin
				// walk from the oldest frame; stop at the first timer past the limit
				fired = 1'b0;
				for (k = 0; k < int'(outst) && !fired; k++) begin
					q = base_ctr + 16'(k);
					s = slot_of(q);
					if (slot_tmr[s] != TIMER_MAX)
						slot_tmr[s] = slot_tmr[s] + 1'b1;
					if (slot_tmr[s] > tmo_reg) begin
						slot_tmr[s]  = '0;
						fired        = 1'b1;
						r.status     = STAT_TIMEOUT;
						r.tx_valid   = 1'b1;
						r.tx_seq     = q;
						r.tx_payload = slot_pay[s];
					end
				end
			end
		endcase
		r.base_seq = base_ctr;
		r.next_seq = next_ctr;
		r.done_res = (base_ctr == total_reg);
		return r;
	endfunction

	// Draw the idle cycles that follow one beat; style 0 never idles.
	function automatic int draw_wait(int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(0, MAX_WAIT);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	// Build a random operation, mostly aimed at the frames now outstanding.
	function automatic frame_op_t draft_op();
		frame_op_t   it;
		int unsigned pick;
		logic [15:0] outst;
		outst        = next_ctr - base_ctr;
		it.operation = OP_TICK;
		it.frame_seq = 16'($urandom);
		it.payload   = $urandom;
		pick         = $urandom_range(0, 99);
		if (pick < 40) begin
			it.operation = OP_OFFER;
		end else if (pick < 72) begin
			it.operation = (pick < 58) ? OP_ACK : OP_NAK;
			if (outst != 0)
				it.frame_seq = base_ctr + 16'($urandom_range(0, int'(outst) - 1));
		end else if (pick >= 90) begin
			// noise: any operation, seq just outside the window or fully random
			it.operation = op_t'(OP_W'($urandom_range(0, 3)));
			case ($urandom_range(0, 2))
				0:       it.frame_seq = next_ctr;
				1:       it.frame_seq = base_ctr - 16'd1;
				default: ;
			endcase
		end
		return it;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("%0t mismatch on result %0d: %s", $realtime, results_seen, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// Hold the filler until the driver has room, then queue the beat.
	task automatic queue_beat(frame_op_t it);
		while (beats_to_send.size() >= 2)
			@(negedge clk);
		beats_to_send.push_back(it);
	endtask

	// Drain: no beat waiting or offered, no result due, then let a tick walk finish.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (beats_to_send.size() != 0 || in_ch.valid || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Drive one register write from the next rising edge and mirror it in the shadow.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_WINDOW:  win_reg   = val[WIN_W-1:0];
			CFG_TIMEOUT: tmo_reg   = val[TMR_W-1:0];
			CFG_TOTAL:   total_reg = val[TOT_W-1:0];
			default:     ;
		endcase
	endtask

	task automatic configure(logic [WIN_W-1:0] win, logic [TMR_W-1:0] tmo, logic [TOT_W-1:0] tot);
		write_reg(CFG_WINDOW, CFG_DATA_W'(win));
		write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
		write_reg(CFG_TOTAL, CFG_DATA_W'(tot));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Driver: offer queued beats on in_ch, hold each until taken, then idle as drawn.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid     <= 1'b0;
			in_ch.operation <= OP_OFFER;
			in_ch.frame_seq <= '0;
			in_ch.payload   <= '0;
			gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				results_due.push_back(advance_window(on_wire));
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					on_wire = beats_to_send.pop_front();
					in_ch.valid     <= 1'b1;
					in_ch.operation <= on_wire.operation;
					in_ch.frame_seq <= on_wire.frame_seq;
					in_ch.payload   <= on_wire.payload;
					gap_left = draw_wait(send_mode);
					sent_beats++;
					if (sent_beats % MODE_SPAN == 0)
						send_mode = $urandom_range(0, 2);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: take result beats, stalling as drawn, and compare with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		window_result_t got;
		window_result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.status     = out_ch.status;
				got.tx_valid   = out_ch.tx_valid;
				got.tx_seq     = out_ch.tx_seq;
				got.tx_payload = out_ch.tx_payload;
				got.base_seq   = out_ch.base_seq;
				got.next_seq   = out_ch.next_seq;
				got.done_res   = out_ch.done_res;
				if (results_due.size() == 0) begin
					flag_mismatch("result beat with no operation outstanding");
				end else begin
					want = results_due.pop_front();
					check_field("status", 32'(got.status), 32'(want.status));
					check_field("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
					check_field("tx_seq", 32'(got.tx_seq), 32'(want.tx_seq));
					check_field("tx_payload", got.tx_payload, want.tx_payload);
					check_field("base_seq", 32'(got.base_seq), 32'(want.base_seq));
					check_field("next_seq", 32'(got.next_seq), 32'(want.next_seq));
					check_field("done_res", 32'(got.done_res), 32'(want.done_res));
				end
				results_seen++;
				stall_left = draw_wait(take_mode);
				taken_beats++;
				if (taken_beats % MODE_SPAN == 0)
					take_mode = $urandom_range(0, 2);
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
			$display("[selective_repeat_sender_window_top] ERROR");
			$finish;
		end
	end

	initial begin
		int phase;
		int n;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_WINDOW;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.operation = OP_OFFER;
		in_ch.frame_seq = '0;
		in_ch.payload   = '0;
		out_ch.ready    = 1'b0;
		// shadow starts from the reset values; payload slots are never read before a send
		win_reg   = WINDOW_RESET;
		tmo_reg   = TIMEOUT_RESET;
		total_reg = '0;
		base_ctr  = '0;
		next_ctr  = '0;
		for (n = 0; n < SLOTS; n++) begin
			slot_pay[n] = '0;
			slot_tmr[n] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: empty transfer, nothing outstanding.
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'h1234_5678});  // refused, no frames left
		queue_beat(frame_op_t'{OP_TICK, 16'h0000, 32'h0000_0000});   // idle, nothing outstanding
		queue_beat(frame_op_t'{OP_ACK, 16'h0000, 32'h0000_0000});    // bad seq, window empty
		queue_beat(frame_op_t'{OP_NAK, 16'hFFFF, 32'hFFFF_FFFF});    // bad seq
		wait_idle();

		// Window register 0 acts as one slot; zero limit fires on the first tick.
		write_reg(CFG_SPARE, '1);
		configure(3'd0, 27'd0, 16'hFFFF);
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'h0000_0000});  // sent as seq 0
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'hFFFF_FFFF});  // refused, window full
		queue_beat(frame_op_t'{OP_TICK, 16'h0000, 32'h0000_0000});   // timeout resend of seq 0
		queue_beat(frame_op_t'{OP_NAK, 16'h0000, 32'h0000_0000});    // nak resend of seq 0
		queue_beat(frame_op_t'{OP_NAK, 16'h0001, 32'h0000_0000});    // bad seq, not yet sent
		queue_beat(frame_op_t'{OP_ACK, 16'hFFFF, 32'h0000_0000});    // bad seq, behind base
		queue_beat(frame_op_t'{OP_ACK, 16'h0000, 32'h0000_0000});    // acked, window empty
		wait_idle();

		// Window register 7 acts as four slots; four frames left in the transfer.
		configure(3'd7, 27'd2, 16'd5);
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'hFFFF_FFFF});
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'hAAAA_AAAA});
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'h5555_5555});
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'h0000_0000});
		queue_beat(frame_op_t'{OP_OFFER, 16'h0000, 32'h0F0F_0F0F});  // refused, transfer used up
		queue_beat(frame_op_t'{OP_TICK, 16'h0000, 32'h0000_0000});   // every timer at 1: idle
		queue_beat(frame_op_t'{OP_TICK, 16'h0000, 32'h0000_0000});   // every timer at 2: idle
		queue_beat(frame_op_t'{OP_TICK, 16'h0000, 32'h0000_0000});   // oldest fires, walk stops
		queue_beat(frame_op_t'{OP_TICK, 16'h0000, 32'h0000_0000});   // next oldest fires
		queue_beat(frame_op_t'{OP_NAK, 16'h0003, 32'h0000_0000});
		queue_beat(frame_op_t'{OP_ACK, 16'h0002, 32'h0000_0000});    // retires two frames
		queue_beat(frame_op_t'{OP_ACK, 16'h0004, 32'h0000_0000});    // retires the rest, done
		queue_beat(frame_op_t'{OP_TICK, 16'h0000, 32'h0000_0000});

		// Random phases, each under its own settings.
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: configure(3'd1, 27'd1, next_ctr + 16'd60);
				1: configure(3'd4, TIMER_MAX, next_ctr + 16'd90);   // timers can never fire
				2: configure(3'd2, 27'd3, next_ctr + 16'($urandom_range(30, 150)));
				3: configure(3'd3, 27'd2, next_ctr);                // no frames left at all
				4: configure(3'd5, 27'd0, next_ctr + 16'($urandom_range(30, 150)));
				5: configure(3'd7, 27'($urandom_range(4, 40)), 16'd0);
				6: configure(3'd0, 27'd5, next_ctr + 16'($urandom_range(30, 150)));
				7: configure(3'd4, 27'd1, 16'hFFFF);
				default: configure(3'($urandom_range(1, 4)), 27'($urandom_range(0, 8)),
					next_ctr + 16'($urandom_range(30, 150)));
			endcase
			for (n = 0; n < PHASE_BEATS; n++)
				queue_beat(draft_op());
		end

		wait_idle();
		if (errors == 0)
			$display("[selective_repeat_sender_window_top] OK");
		else
			$display("[selective_repeat_sender_window_top] ERROR");
		$finish;
	end

endmodule
